// ===== rtl/ktps_pkg.sv =====
// Package for the kiln thermal plant step block: widths, reset values,
// register indexes, sequencer states and the temperature saturation function.
// Depends on nothing; imported by kiln_thermal_plant_step.
package ktps_pkg;

  localparam int TEMP_WIDTH = 16;
  localparam int CFG_W      = 16;
  localparam int STEP_W     = 16;
  localparam int DRIVE_W    = 9;
  localparam int INV_W      = 16;
  localparam int GAIN_W     = 24;
  localparam int NUM_INV    = 5;
  localparam int NUM_REGS   = 7;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  // Difference of a 16-bit register and a temperature.
  localparam int SPAN_W = ((TEMP_WIDTH > CFG_W) ? TEMP_WIDTH : CFG_W) + 1;
  // Extrapolated targets with drive up to 511/256 plus the base temperature.
  localparam int TGT_W  = SPAN_W + 3;
  localparam int MA_W   = TGT_W + 1;
  localparam int MB_W   = GAIN_W + 1;
  localparam int P_W    = MA_W + MB_W;
  localparam int SUM_W  = P_W - 15;

  localparam logic signed [TEMP_WIDTH-1:0] TEMP_RESET       = TEMP_WIDTH'(-1280);
  localparam logic signed [CFG_W-1:0]      HEATER_MAX_RESET = CFG_W'(11520);
  localparam logic signed [CFG_W-1:0]      OUTSIDE_RESET    = CFG_W'(-1280);

  typedef logic [2:0] stage_t;
  localparam stage_t STG_HEAT = 3'd0;  // heater toward its power target
  localparam stage_t STG_H2C  = 3'd1;  // chamber toward heater
  localparam stage_t STG_W2C  = 3'd2;  // chamber toward wood
  localparam stage_t STG_AIR  = 3'd3;  // chamber toward outside air mix
  localparam stage_t STG_C2W  = 3'd4;  // wood toward chamber

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_HEATER_MAX = 3'd0;
  localparam reg_idx_t REG_OUTSIDE    = 3'd1;
  localparam reg_idx_t REG_INV_HEAT   = 3'd2;
  localparam reg_idx_t REG_INV_H2C    = 3'd3;
  localparam reg_idx_t REG_INV_W2C    = 3'd4;
  localparam reg_idx_t REG_INV_AIR    = 3'd5;
  localparam reg_idx_t REG_INV_C2W    = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TGT,
    S_GAIN,
    S_LAG,
    S_UPD,
    S_DONE
  } state_t;

  function automatic logic signed [TEMP_WIDTH-1:0] sat_temp(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-TEMP_WIDTH+1){1'b0}}, {(TEMP_WIDTH-1){1'b1}}};
    lo = {{(SUM_W-TEMP_WIDTH+1){1'b1}}, {(TEMP_WIDTH-1){1'b0}}};
    if (v > hi) begin
      sat_temp = hi[TEMP_WIDTH-1:0];
    end else if (v < lo) begin
      sat_temp = lo[TEMP_WIDTH-1:0];
    end else begin
      sat_temp = v[TEMP_WIDTH-1:0];
    end
  endfunction

endpackage

// ===== rtl/kiln_thermal_plant_step.sv =====
// Kiln thermal plant step: top level with the register port, the sequencer
// and the one shared multiplier that performs all lag updates.
// Depends on ktps_pkg.

// The block models a drying kiln with three temperatures (heater, chamber air
// and wood) and advances the model by one time step for every input beat. A
// beat carries the step length, the heater power and the damper opening; the
// result beat carries the three temperatures after the step, in 1/128 degree
// units, saturated to the signed temperature range. Each step runs five
// first-order lag updates in a fixed order: heater toward its power target,
// chamber toward heater, chamber toward wood, chamber toward a mix of itself
// and outside air, and finally wood toward chamber. All arithmetic goes
// through one signed multiplier whose product is registered; the sequencer
// feeds it the gain (step length times reciprocal time constant), the lag
// product and, for the two mixed targets, the target product. From acceptance
// until the result is loaded into the output register an item goes through
// twelve multiplier passes, five update steps and the done state, which hands
// the result over, and in_ready stays low during that time. The input
// side is taken again the cycle after the result is loaded, even while the
// result still waits for out_ready; a new result waits in the sequencer until
// the output register is free. The seven registers sit at byte addresses 0 to
// 24 on the APB-style port and should be written only while the block is idle.
module kiln_thermal_plant_step
  import ktps_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [DATA_W-1:0]            pwdata,
  output logic [DATA_W-1:0]            prdata,
  output logic                         pready,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [STEP_W-1:0]            step_length,
  input  logic [DRIVE_W-1:0]           heater_power,
  input  logic [DRIVE_W-1:0]           damper_open,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [TEMP_WIDTH-1:0] wood_temp_out,
  output logic signed [TEMP_WIDTH-1:0] chamber_temp_out,
  output logic signed [TEMP_WIDTH-1:0] heater_temp_out
);

  // Configuration registers.
  logic signed [CFG_W-1:0] heater_max;
  logic signed [CFG_W-1:0] outside_temp;
  logic [INV_W-1:0]        inv_tc [NUM_INV];

  // Plant state.
  logic signed [TEMP_WIDTH-1:0] heater_temp;
  logic signed [TEMP_WIDTH-1:0] chamber_temp;
  logic signed [TEMP_WIDTH-1:0] wood_temp;

  // Sequencer and datapath.
  state_t                   state;
  state_t                   state_next;
  stage_t                   stage;
  logic [STEP_W-1:0]        step_q;
  logic [DRIVE_W-1:0]       power_q;
  logic [DRIVE_W-1:0]       damper_q;
  logic signed [TGT_W-1:0]  target;
  logic signed [TGT_W-1:0]  stage_target;
  logic signed [P_W-1:0]    prod;
  logic signed [MA_W-1:0]   mult_a;
  logic signed [MB_W-1:0]   mult_b;
  logic signed [TEMP_WIDTH-1:0] cur_temp;
  logic signed [SUM_W-1:0]  lag_sum;
  logic signed [TEMP_WIDTH-1:0] lag_new;
  logic signed [TGT_W-1:0]  chamber_ext;
  logic                     cfg_write;
  logic                     out_load;

  // ---------------------------------------------------------------------------
  // Register port. Writes land at the access phase; reads are combinational.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      heater_max   <= HEATER_MAX_RESET;
      outside_temp <= OUTSIDE_RESET;
      inv_tc[0]    <= INV_W'(2560);
      inv_tc[1]    <= INV_W'(512);
      inv_tc[2]    <= INV_W'(1707);
      inv_tc[3]    <= INV_W'(512);
      inv_tc[4]    <= INV_W'(171);
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_HEATER_MAX: heater_max   <= pwdata[CFG_W-1:0];
        REG_OUTSIDE:    outside_temp <= pwdata[CFG_W-1:0];
        REG_INV_HEAT:   inv_tc[0]    <= pwdata[INV_W-1:0];
        REG_INV_H2C:    inv_tc[1]    <= pwdata[INV_W-1:0];
        REG_INV_W2C:    inv_tc[2]    <= pwdata[INV_W-1:0];
        REG_INV_AIR:    inv_tc[3]    <= pwdata[INV_W-1:0];
        REG_INV_C2W:    inv_tc[4]    <= pwdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_HEATER_MAX: prdata = DATA_W'({1'b0, heater_max});
      REG_OUTSIDE:    prdata = DATA_W'({1'b0, outside_temp});
      REG_INV_HEAT:   prdata = DATA_W'(inv_tc[0]);
      REG_INV_H2C:    prdata = DATA_W'(inv_tc[1]);
      REG_INV_W2C:    prdata = DATA_W'(inv_tc[2]);
      REG_INV_AIR:    prdata = DATA_W'(inv_tc[3]);
      REG_INV_C2W:    prdata = DATA_W'(inv_tc[4]);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer. Each stage is an optional target pass, a gain pass, a lag
  // pass and an update cycle.
  // ---------------------------------------------------------------------------
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_TGT;
        end
      end
      S_TGT:  state_next = S_GAIN;
      S_GAIN: state_next = S_LAG;
      S_LAG:  state_next = S_UPD;
      S_UPD: begin
        if (stage == STG_C2W) begin
          state_next = S_DONE;
        end else if (stage == STG_W2C) begin
          state_next = S_TGT;
        end else begin
          state_next = S_GAIN;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // ---------------------------------------------------------------------------
  // Operand selection for the shared multiplier.
  // ---------------------------------------------------------------------------
  assign chamber_ext = TGT_W'(chamber_temp);

  always_comb begin
    case (stage)
      STG_HEAT: cur_temp = heater_temp;
      STG_C2W:  cur_temp = wood_temp;
      default:  cur_temp = chamber_temp;
    endcase
  end

  // Target of the current stage; for the two mixed targets the registered
  // product holds the scaled span from the target pass.
  always_comb begin
    case (stage)
      STG_HEAT: stage_target = chamber_ext + prod[8+TGT_W-1:8];
      STG_H2C:  stage_target = TGT_W'(heater_temp);
      STG_W2C:  stage_target = TGT_W'(wood_temp);
      STG_AIR:  stage_target = chamber_ext + prod[9+TGT_W-1:9];
      default:  stage_target = chamber_ext;
    endcase
  end

  always_comb begin
    mult_a = '0;
    mult_b = '0;
    unique case (state)
      S_TGT: begin
        if (stage == STG_HEAT) begin
          mult_a = MA_W'(heater_max) - MA_W'(chamber_temp);
          mult_b = MB_W'({1'b0, power_q});
        end else begin
          mult_a = MA_W'(outside_temp) - MA_W'(chamber_temp);
          mult_b = MB_W'({1'b0, damper_q});
        end
      end
      S_GAIN: begin
        mult_a = MA_W'({1'b0, step_q});
        mult_b = MB_W'({1'b0, inv_tc[stage]});
      end
      S_LAG: begin
        mult_a = MA_W'(target) - MA_W'(cur_temp);
        mult_b = MB_W'({1'b0, prod[8+GAIN_W-1:8]});
      end
      default: ;
    endcase
  end

  // Lag update: the product is floored by 2^16 through the arithmetic slice.
  assign lag_sum = {prod[P_W-1], prod[P_W-1:16]}
                 + {{(SUM_W-TEMP_WIDTH){cur_temp[TEMP_WIDTH-1]}}, cur_temp};
  assign lag_new = sat_temp(lag_sum);

  // ---------------------------------------------------------------------------
  // Datapath registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    prod <= mult_a * mult_b;
    if (in_valid && in_ready) begin
      step_q   <= step_length;
      power_q  <= heater_power;
      damper_q <= damper_open;
    end
    if (state == S_GAIN) begin
      target <= stage_target;
    end
    if (out_load) begin
      wood_temp_out    <= wood_temp;
      chamber_temp_out <= chamber_temp;
      heater_temp_out  <= heater_temp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage        <= STG_HEAT;
      heater_temp  <= TEMP_RESET;
      chamber_temp <= TEMP_RESET;
      wood_temp    <= TEMP_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        stage <= STG_HEAT;
      end else if (state == S_UPD && stage != STG_C2W) begin
        stage <= stage + 3'd1;
      end
      if (state == S_UPD) begin
        case (stage)
          STG_HEAT: heater_temp  <= lag_new;
          STG_C2W:  wood_temp    <= lag_new;
          default:  chamber_temp <= lag_new;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while a step is in progress");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result appeared without a finished step");

  a_target_stages: assert property (@(posedge clk) disable iff (rst)
    state == S_TGT |-> (stage == STG_HEAT || stage == STG_AIR))
    else $error("target pass in a stage with a plain target");

  a_stage_range: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> stage <= STG_C2W)
    else $error("stage counter out of range");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && $past(state) != S_DONE |-> $past(stage == STG_C2W))
    else $error("step finished before the last lag update");

endmodule
